/* design/lce_pkg.sv */
// Shared constants, types and helpers of the life cellular automaton engine.
`default_nettype none
package lce_pkg;

	localparam int MAX_WIDTH  = 128;
	localparam int MAX_HEIGHT = 128;
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int SIZE_W     = 8;

	localparam logic [1:0] CMD_WRITE   = 2'd0;
	localparam logic [1:0] CMD_READ    = 2'd1;
	localparam logic [1:0] CMD_ADVANCE = 2'd2;
	localparam logic [1:0] CMD_CLEAR   = 2'd3;

	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	localparam logic [1:0] RS_ITEM = 2'd0;
	localparam logic [1:0] RS_ROW  = 2'd1;
	localparam logic [1:0] RS_NEXT = 2'd2;

	localparam logic [1:0] WS_CELL = 2'd0;
	localparam logic [1:0] WS_GEN  = 2'd1;
	localparam logic [1:0] WS_ZERO = 2'd2;

	typedef struct packed {
		logic       ld_item;
		logic [1:0] rsel;
		logic [1:0] wsel;
		logic       we;
		logic       ld_here;
		logic       gen_step;
		logic       row_inc;
		logic       cap_rv;
		logic       ld_out;
	} lce_ctl_t;

	typedef struct packed {
		logic [1:0] item_cmd;
		logic       row_last_max;
		logic       row_last_gen;
	} lce_sts_t;

	// Limit a size register to 1..maxv.
	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
		input logic [SIZE_W-1:0] maxv);
		logic [SIZE_W-1:0] r;
		if (v == '0) r = SIZE_W'(1);
		else if (v > maxv) r = maxv;
		else r = v;
		return r;
	endfunction

endpackage
`default_nettype wire

/* design/life_cellular_automaton_engine.sv */
// Top level of the life cellular automaton engine (B3/S23, bounded grid).
//
// Channel   Direction  Contents
// s_axis    in         request: cmd, row, col, cell_value
// m_axis    out        result: read_value, done_cmd
// cfg       in         register writes: 0 grid_width, 1 grid_height
//
// Write and read pass through dispatch, the cell access and the done state; clear
// writes one row of the store per cycle; advance alternates computing a row and
// reading the next, bounded by the single read port of the row store.
// After reset a sweep clears all 128 rows of the store; no request is taken meanwhile.
// A new request is taken while an earlier result waits on m_axis.
`default_nettype none
module life_cellular_automaton_engine (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,  // cmd[1:0], row[8:2], col[15:9], cell_value[16]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,  // read_value[0], done_cmd[2:1]
	input  wire logic        cfg_we,
	input  wire logic        cfg_addr,
	input  wire logic [7:0]  cfg_wdata
);

	lce_pkg::lce_ctl_t ctl;
	lce_pkg::lce_sts_t sts;

	lce_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	lce_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.sts      (sts),
		.in_data  (s_axis_tdata),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.out_data (m_axis_tdata)
	);

endmodule
`default_nettype wire

/* design/lce_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lce_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

/* design/lce_dp.sv */
// Datapath: config registers, row store, row buffers and the B3/S23 row update.
`default_nettype none
module lce_dp (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lce_pkg::lce_ctl_t ctl,
	output lce_pkg::lce_sts_t      sts,
	input  wire logic [23:0]       in_data,
	input  wire logic              cfg_we,
	input  wire logic              cfg_addr,
	input  wire logic [7:0]        cfg_wdata,
	output logic [7:0]             out_data
);

	localparam int W = lce_pkg::MAX_WIDTH;
	localparam logic [1:0] RS_ITEM_SEL = lce_pkg::RS_ITEM;
	localparam logic [1:0] RS_NEXT_SEL = lce_pkg::RS_NEXT;

	logic [lce_pkg::SIZE_W-1:0] width_q, height_q, w_eff, h_eff;
	logic [1:0]                 cmd_q;
	logic [lce_pkg::ROW_W-1:0]  row_q, r_q, raddr, waddr;
	logic [lce_pkg::COL_W-1:0]  col_q;
	logic                       val_q, rv_q, in_grid;
	logic [W-1:0]               rdata, wdata, below_q, here_q, above, mod_row, new_row, wmask;
	logic [W-1:0]               b_m, h_m, a_m;
	logic [3:0]                 n;
	logic [7:0]                 out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= lce_pkg::SIZE_W'(100);
			height_q <= lce_pkg::SIZE_W'(100);
		end else if (cfg_we) begin
			if (cfg_addr == lce_pkg::CFG_WIDTH) width_q <= cfg_wdata;
			else height_q <= cfg_wdata;
		end
	end

	assign w_eff = lce_pkg::clamp_size(width_q, lce_pkg::SIZE_W'(lce_pkg::MAX_WIDTH));
	assign h_eff = lce_pkg::clamp_size(height_q, lce_pkg::SIZE_W'(lce_pkg::MAX_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) r_q <= '0;
		else if (ctl.ld_item) r_q <= '0;
		else if (ctl.row_inc || ctl.gen_step) r_q <= r_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_item) begin
			cmd_q <= in_data[1:0];
			row_q <= in_data[8:2];
			col_q <= in_data[15:9];
			val_q <= in_data[16];
			rv_q  <= 1'b0;
		end else if (ctl.cap_rv) begin
			rv_q <= rdata[col_q] & in_grid;
		end
		if (ctl.ld_here) begin
			here_q  <= rdata;
			below_q <= '0;
		end else if (ctl.gen_step) begin
			below_q <= here_q;
			here_q  <= above;
		end
		if (ctl.ld_out) out_q <= {5'b0, cmd_q, rv_q};
	end

	assign in_grid = ({1'b0, row_q} < h_eff) && ({1'b0, col_q} < w_eff);
	assign sts.item_cmd     = cmd_q;
	assign sts.row_last_max = (r_q == lce_pkg::ROW_W'(lce_pkg::MAX_HEIGHT - 1));
	assign sts.row_last_gen = ({1'b0, r_q} + 1'b1) == h_eff;

	always_comb begin
		case (ctl.rsel)
			RS_ITEM_SEL: raddr = row_q;
			RS_NEXT_SEL: raddr = r_q + 1'b1;
			default:     raddr = r_q;
		endcase
	end

	// Rows at or above the grid top contribute dead neighbours.
	assign above = sts.row_last_gen ? '0 : rdata;

	always_comb begin
		for (int c = 0; c < W; c++) begin
			wmask[c]   = (c < int'(w_eff));
			mod_row[c] = (c == int'(col_q)) ? val_q : rdata[c];
		end
		b_m = below_q & wmask;
		h_m = here_q & wmask;
		a_m = above & wmask;
		for (int c = 0; c < W; c++) begin
			n = 4'(b_m[c]) + 4'(a_m[c]);
			if (c > 0) n = n + 4'(b_m[c-1]) + 4'(h_m[c-1]) + 4'(a_m[c-1]);
			if (c < W - 1) n = n + 4'(b_m[c+1]) + 4'(h_m[c+1]) + 4'(a_m[c+1]);
			new_row[c] = wmask[c] ? ((n == 4'd3) || ((n == 4'd2) && here_q[c])) : here_q[c];
		end
	end

	always_comb begin
		case (ctl.wsel)
			lce_pkg::WS_CELL: begin
				wdata = mod_row;
				waddr = row_q;
			end
			lce_pkg::WS_GEN: begin
				wdata = new_row;
				waddr = r_q;
			end
			default: begin
				wdata = '0;
				waddr = r_q;
			end
		endcase
	end

	lce_ram #(
		.WIDTH(W),
		.DEPTH(lce_pkg::MAX_HEIGHT)
	) u_store (
		.clk  (clk),
		.we   (ctl.we && (ctl.wsel != lce_pkg::WS_CELL || in_grid)),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign out_data = out_q;

endmodule
`default_nettype wire

/* design/lce_ctrl.sv */
// Controller: sequences commands, clearing sweeps and generation steps.
`default_nettype none
module lce_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire lce_pkg::lce_sts_t sts,
	output lce_pkg::lce_ctl_t      ctl
);

	localparam logic [3:0] S_INIT = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_DISP = 4'd2;
	localparam logic [3:0] S_MOD  = 4'd3;
	localparam logic [3:0] S_GLD  = 4'd4;
	localparam logic [3:0] S_GCMP = 4'd5;
	localparam logic [3:0] S_GRA  = 4'd6;
	localparam logic [3:0] S_CLR  = 4'd7;
	localparam logic [3:0] S_DONE = 4'd8;

	logic [3:0] state_q, state_d;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		ctl.rsel = lce_pkg::RS_ROW;
		ctl.wsel = lce_pkg::WS_ZERO;
		case (state_q)
			S_INIT: begin
				ctl.we      = 1'b1;
				ctl.row_inc = 1'b1;
				if (sts.row_last_max) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					ctl.ld_item = 1'b1;
					state_d     = S_DISP;
				end
			end
			S_DISP: begin
				case (sts.item_cmd)
					lce_pkg::CMD_WRITE, lce_pkg::CMD_READ: begin
						ctl.rsel = lce_pkg::RS_ITEM;
						state_d  = S_MOD;
					end
					lce_pkg::CMD_ADVANCE: state_d = S_GLD;
					default:              state_d = S_CLR;
				endcase
			end
			S_MOD: begin
				ctl.wsel = lce_pkg::WS_CELL;
				ctl.we   = (sts.item_cmd == lce_pkg::CMD_WRITE);
				ctl.cap_rv = (sts.item_cmd == lce_pkg::CMD_READ);
				state_d  = S_DONE;
			end
			S_GLD: begin
				ctl.ld_here = 1'b1;
				ctl.rsel    = lce_pkg::RS_NEXT;
				state_d     = S_GCMP;
			end
			S_GCMP: begin
				ctl.wsel     = lce_pkg::WS_GEN;
				ctl.we       = 1'b1;
				ctl.gen_step = 1'b1;
				state_d      = sts.row_last_gen ? S_DONE : S_GRA;
			end
			S_GRA: begin
				ctl.rsel = lce_pkg::RS_NEXT;
				state_d  = S_GCMP;
			end
			S_CLR: begin
				ctl.we      = 1'b1;
				ctl.row_inc = 1'b1;
				if (sts.row_last_max) state_d = S_DONE;
			end
			S_DONE: begin
				// hold the result until the output register frees up
				if (!out_valid_q || out_ready) begin
					ctl.ld_out = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.ld_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire
